[hdl/kms_pkg.sv]
// Package for the key matrix scanner: command codes, configuration register
// indexes, port widths and the low-bit mask helper. No dependencies.
package kms_pkg;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int ROW_W      = 8;
    localparam int COL_OUT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SHIFT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_WIDTH   = 2'd3;

    typedef logic [ROW_W-1:0] t_rows;

    // Mask of the n low bits, saturating at the full row width.
    function automatic t_rows low_mask(input logic [CFG_DATA_W-1:0] n);
        t_rows m;
        if (n >= CFG_DATA_W'(ROW_W)) begin
            m = '1;
        end else begin
            m = ROW_W'((9'd1 << n) - 9'd1);
        end
        return m;
    endfunction

endpackage

[hdl/kms_if.sv]
// Valid/ready channel interfaces for the key matrix scanner: input items
// and result items. Depends on kms_pkg.
interface kms_in_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    kms_pkg::t_rows      row_port;

    modport source (output valid, output cmd, output row_port, input ready);
    modport sink   (input valid, input cmd, input row_port, output ready);
endinterface

interface kms_out_if;
    logic                             valid;
    logic                             ready;
    logic [kms_pkg::COL_OUT_W-1:0]    column;
    kms_pkg::t_rows                   new_presses;
    kms_pkg::t_rows                   column_drive;

    modport source (output valid, output column, output new_presses,
                    output column_drive, input ready);
    modport sink   (input valid, input column, input new_presses,
                    input column_drive, output ready);
endinterface

[hdl/kms_row_store.sv]
// Previous-row store: one row word per column in a synchronous memory with
// per-entry valid bits and write-to-read forwarding. Depends on kms_pkg.
module kms_row_store #(
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  kms_pkg::t_rows           i_reset_value,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  kms_pkg::t_rows           i_wr_data,
    output kms_pkg::t_rows           o_rd_data
);

    kms_pkg::t_rows   mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    kms_pkg::t_rows   r_rd_data;
    logic             r_rd_hit;
    logic             r_fwd;
    kms_pkg::t_rows   r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // An entry never written since reset or a row count change reads as released.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Capture a same-edge write to the read entry and forward it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_rd_hit   <= r_valid[i_rd_addr];
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd    ? r_fwd_data :
                       r_rd_hit ? r_rd_data  : i_reset_value;

endmodule

[hdl/key_matrix_scanner.sv]
// Key matrix scanner, top level. Uses kms_pkg, kms_if and kms_row_store.
// A tick item advances the active column round robin, wrapping at the
// configured column count (capped at COLUMNS, zero acting as one); a sample
// item takes the row port, shifts it right by row_shift, masks it to
// row_count bits and reports rows that went from released (1) to pressed (0)
// since the last sample of the active column, limited to the low scan_width
// bits, then stores the new rows for that column. Every item yields exactly
// one result carrying the active column, the new presses (zero for a tick)
// and the active-low one-hot column drive. Items flow at one per cycle while
// the output does not stall: an item reads the previous-row memory on
// acceptance, the press compare and write-back happen in the compare stage
// as the item leaves it, and a result register decouples the output. A
// sample of the column written in the same cycle is served by forwarding
// inside the row store. Writing column_count returns the active column to
// zero; writing row_count marks every stored row as released. Configure
// only while no item is in flight.
module key_matrix_scanner #(
    parameter int COLUMNS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kms_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    kms_in_if.sink                          i_in,
    kms_out_if.source                       o_out
);

    localparam int CW = $clog2(COLUMNS);
    localparam logic [kms_pkg::CFG_DATA_W-1:0] ColsMax = kms_pkg::CFG_DATA_W'(COLUMNS);

    // Configuration registers
    logic [kms_pkg::CFG_DATA_W-1:0] r_column_count;
    logic [kms_pkg::CFG_DATA_W-1:0] r_row_count;
    logic [2:0]                     r_row_shift;
    logic [kms_pkg::CFG_DATA_W-1:0] r_scan_width;

    logic [CW-1:0] r_col;

    // Press-compare stage
    logic           r_s1_valid;
    logic           r_s1_sample;
    logic [CW-1:0]  r_s1_col;
    kms_pkg::t_rows r_s1_now;

    // Result register
    logic                          r_out_valid;
    logic [kms_pkg::COL_OUT_W-1:0] r_out_col;
    kms_pkg::t_rows                r_out_presses;
    kms_pkg::t_rows                r_out_drive;

    logic                           accept;
    logic                           s1_move;
    logic                           in_sample;
    logic [kms_pkg::CFG_DATA_W-1:0] used_cols;
    logic [kms_pkg::CFG_DATA_W-1:0] n_col_ext;
    logic [CW-1:0]                  n_col;
    kms_pkg::t_rows                 row_mask;
    kms_pkg::t_rows                 sampled_rows;
    kms_pkg::t_rows                 prev_rows;
    kms_pkg::t_rows                 s1_presses;
    logic                           cfg_col_wr;
    logic                           cfg_row_wr;

    assign cfg_col_wr = i_cfg_we && (i_cfg_idx == kms_pkg::REG_COLUMN_COUNT);
    assign cfg_row_wr = i_cfg_we && (i_cfg_idx == kms_pkg::REG_ROW_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= ColsMax;
            r_row_count    <= kms_pkg::CFG_DATA_W'(kms_pkg::ROW_W);
            r_row_shift    <= '0;
            r_scan_width   <= kms_pkg::CFG_DATA_W'(kms_pkg::ROW_W);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kms_pkg::REG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                kms_pkg::REG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                kms_pkg::REG_ROW_SHIFT:    r_row_shift    <= i_cfg_data[2:0];
                kms_pkg::REG_SCAN_WIDTH:   r_scan_width   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: advance the compare stage when the result register frees up.
    assign s1_move    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign accept     = i_in.valid && i_in.ready;
    assign in_sample  = (i_in.cmd == kms_pkg::CMD_SAMPLE);

    // Round-robin advance: wrap at the clamped column count.
    always_comb begin
        if (r_column_count > ColsMax) begin
            used_cols = ColsMax;
        end else if (r_column_count == '0) begin
            used_cols = kms_pkg::CFG_DATA_W'(1);
        end else begin
            used_cols = r_column_count;
        end
        n_col_ext = kms_pkg::CFG_DATA_W'(r_col) + kms_pkg::CFG_DATA_W'(1);
        if (n_col_ext >= used_cols) begin
            n_col = '0;
        end else begin
            n_col = n_col_ext[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_col_wr) begin
            r_col <= '0;
        end else if (accept && !in_sample) begin
            r_col <= n_col;
        end
    end

    assign row_mask     = kms_pkg::low_mask(r_row_count);
    assign sampled_rows = kms_pkg::ROW_W'(i_in.row_port >> r_row_shift) & row_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= in_sample;
            r_s1_col    <= in_sample ? r_col : n_col;
            r_s1_now    <= sampled_rows;
        end
    end

    // Read on acceptance, write back as the item leaves the compare stage.
    kms_row_store #(
        .DEPTH(COLUMNS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_row_wr),
        .i_reset_value(row_mask),
        .i_rd_en      (accept && in_sample),
        .i_rd_addr    (r_col),
        .i_wr_en      (s1_move && r_s1_sample),
        .i_wr_addr    (r_s1_col),
        .i_wr_data    (r_s1_now),
        .o_rd_data    (prev_rows)
    );

    // New press: released before, pressed now, within the scan width.
    assign s1_presses = r_s1_sample ?
                        (~r_s1_now & prev_rows & kms_pkg::low_mask(r_scan_width)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_col     <= kms_pkg::COL_OUT_W'(r_s1_col);
            r_out_presses <= s1_presses;
            r_out_drive   <= ~(kms_pkg::ROW_W'(1) << r_s1_col);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.column       = r_out_col;
    assign o_out.new_presses  = r_out_presses;
    assign o_out.column_drive = r_out_drive;

    // An accepted item never lands on an occupied compare stage.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!r_s1_valid || s1_move))
        else $error("item accepted over a held compare stage");

    // A held result is never replaced.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten while stalled");

    // The active column stays below the columns in use.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kms_pkg::CFG_DATA_W'(r_col) < used_cols)
        else $error("active column beyond column count");

    // A tick never reports presses.
    a_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_sample) |-> (s1_presses == '0))
        else $error("tick item carries presses");

endmodule
